// File: hdl/mcme_pkg.sv
// Shared types, constants and helpers for the multi-camera motion event block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mcme_pkg;

	// Camera count of the system; the item carries four ratios, so lanes are clipped to four.
	localparam int CAMERAS = 4;
	localparam int LANES = (CAMERAS < 4) ? CAMERAS : 4;

	localparam int RATIO_W = 16;
	localparam int TIME_W = 32;
	localparam int MASK_W = 4;
	localparam int COUNT_W = 3;
	localparam int SUM_W = RATIO_W + 2;
	localparam int SETTLE_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [SETTLE_W-1:0] SETTLE_MAX = {SETTLE_W{1'b1}};
	localparam logic [RATIO_W-1:0] ELAPSED_MAX = {RATIO_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_SPIKE = 3'd1,
		ST_STAB = 3'd2,
		ST_END = 3'd3,
		ST_COOL = 3'd4
	} state_t;

	typedef enum logic [1:0] {
		TO_NONE = 2'd0,
		TO_DURATION = 2'd1,
		TO_WINDOW = 2'd2
	} timeout_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPIKE_LEVEL = 3'd0,
		CFG_QUIET_LEVEL = 3'd1,
		CFG_MIN_CAMERAS = 3'd2,
		CFG_SPIKE_WINDOW = 3'd3,
		CFG_MAX_EVENT = 3'd4,
		CFG_SETTLE_FRAMES = 3'd5,
		CFG_COOLDOWN = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [RATIO_W-1:0] spike_level;
		logic [RATIO_W-1:0] quiet_level;
		logic [COUNT_W-1:0] min_cameras;
		logic [15:0] window_ms;
		logic [15:0] max_event_ms;
		logic [SETTLE_W-1:0] settle_frames;
		logic [15:0] cooldown_ms;
	} cfg_t;

	// What one camera lane reports for the current frame.
	typedef struct packed {
		logic measured;
		logic spiking;
		logic [RATIO_W-1:0] ratio;
	} lane_t;

	// Merged frame summary handed to the state machine.
	typedef struct packed {
		logic [MASK_W-1:0] spiking;
		logic settled;
		logic avg_spike;
		logic peak_spike;
	} frame_t;

	typedef struct packed {
		state_t state;
		logic finished;
		logic [15:0] elapsed;
		timeout_t tkind;
		logic [COUNT_W-1:0] spiked_count;
	} result_t;

	function automatic logic [COUNT_W-1:0] popcount4(input logic [MASK_W-1:0] m);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MASK_W; i++) begin
			n = n + COUNT_W'(m[i]);
		end
		return n;
	endfunction

endpackage

// File: hdl/mcme_lane.sv
// One camera lane: masks the ratio by its measured bit and tests it against the spike level.
// Depends on mcme_pkg.
`timescale 1ns / 1ps

module mcme_lane
	import mcme_pkg::*;
(
	input  logic               measured,
	input  logic [RATIO_W-1:0] ratio,
	input  logic [RATIO_W-1:0] spike_level,
	output lane_t              lane
);

	// An unmeasured camera reads as zero and can never spike.
	always_comb begin
		lane.measured = measured;
		lane.ratio = measured ? ratio : '0;
		lane.spiking = measured && (ratio > spike_level);
	end

endmodule

// File: hdl/mcme_merge.sv
// Merges the lane results into sum, count and the level tests used by the state machine.
// Depends on mcme_pkg.
`timescale 1ns / 1ps

module mcme_merge
	import mcme_pkg::*;
(
	input  lane_t              lanes [LANES],
	input  logic [RATIO_W-1:0] spike_level,
	input  logic [RATIO_W-1:0] quiet_level,
	output frame_t             frame
);

	logic [SUM_W-1:0] sum;
	logic [COUNT_W-1:0] count;
	logic [MASK_W-1:0] spiking;
	logic [SUM_W-1:0] quiet_limit;
	logic [SUM_W-1:0] spike_limit;

	always_comb begin
		sum = '0;
		count = '0;
		spiking = '0;
		for (int i = 0; i < LANES; i++) begin
			sum = sum + SUM_W'(lanes[i].ratio);
			count = count + COUNT_W'(lanes[i].measured);
			spiking[i] = lanes[i].spiking;
		end
	end

	// The average is compared as sum against level times count, so no divider is needed.
	assign quiet_limit = SUM_W'(quiet_level) * SUM_W'(count);
	assign spike_limit = SUM_W'(spike_level) * SUM_W'(count);

	always_comb begin
		frame.spiking = spiking;
		frame.settled = (sum <= quiet_limit);
		frame.avg_spike = (sum > spike_limit);
		frame.peak_spike = |spiking;
	end

endmodule

// File: hdl/mcme_fsm.sv
// Event state machine: tracks spiked cameras, timeouts, settling and cooldown, and
// registers one result per frame. Depends on mcme_pkg.
`timescale 1ns / 1ps

module mcme_fsm
	import mcme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  frame_t            frame,
	input  logic [TIME_W-1:0] now,
	input  cfg_t              cfg,
	output result_t           result
);

	state_t state_q, state_d;
	logic [TIME_W-1:0] event_start_q, event_start_d;
	logic [TIME_W-1:0] cooldown_start_q, cooldown_start_d;
	logic [MASK_W-1:0] spiked_mask_q, spiked_mask_d;
	logic [SETTLE_W-1:0] settle_count_q, settle_count_d;
	result_t res_s2;

	logic [TIME_W-1:0] dur;
	logic [TIME_W-1:0] cool_dur;
	logic [MASK_W-1:0] joined_mask;
	logic [COUNT_W-1:0] joined_n;
	logic [SETTLE_W-1:0] settle_inc;
	logic over_max;
	logic over_window;
	logic enough;
	logic finished;
	timeout_t tkind;
	logic [15:0] elapsed;

	assign dur = now - event_start_q;
	assign cool_dur = now - cooldown_start_q;
	assign joined_mask = spiked_mask_q | frame.spiking;
	assign joined_n = popcount4(joined_mask);
	assign enough = (joined_n >= cfg.min_cameras);
	assign over_max = (dur > TIME_W'(cfg.max_event_ms));
	assign over_window = (dur > TIME_W'(cfg.window_ms));
	assign settle_inc = (settle_count_q < SETTLE_MAX) ? settle_count_q + 1'b1 : settle_count_q;

	// Next state and event registers.
	always_comb begin
		state_d = state_q;
		event_start_d = event_start_q;
		cooldown_start_d = cooldown_start_q;
		spiked_mask_d = spiked_mask_q;
		settle_count_d = settle_count_q;
		case (state_q)
			ST_SPIKE: begin
				spiked_mask_d = joined_mask;
				if (enough && frame.settled) begin
					state_d = ST_STAB;
					settle_count_d = SETTLE_W'(1);
				end else if (over_max || (over_window && !enough)) begin
					state_d = ST_IDLE;
				end
			end
			ST_STAB: begin
				if (over_max) begin
					state_d = ST_IDLE;
				end else if (frame.settled) begin
					settle_count_d = settle_inc;
					if (settle_inc >= cfg.settle_frames) begin
						state_d = ST_COOL;
						cooldown_start_d = now;
					end
				end else if (frame.avg_spike) begin
					state_d = ST_SPIKE;
					event_start_d = now;
					spiked_mask_d = frame.spiking;
					settle_count_d = '0;
				end else begin
					settle_count_d = '0;
				end
			end
			ST_END: begin
				state_d = ST_COOL;
				cooldown_start_d = now;
			end
			ST_COOL: begin
				if (cool_dur >= TIME_W'(cfg.cooldown_ms)) begin
					state_d = ST_IDLE;
				end else if (frame.peak_spike) begin
					state_d = ST_SPIKE;
					event_start_d = now;
					spiked_mask_d = frame.spiking;
					settle_count_d = '0;
				end
			end
			default: begin
				if (frame.peak_spike) begin
					state_d = ST_SPIKE;
					event_start_d = now;
					spiked_mask_d = frame.spiking;
					settle_count_d = '0;
				end else begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// Per-frame report fields.
	always_comb begin
		finished = 1'b0;
		tkind = TO_NONE;
		elapsed = '0;
		case (state_q)
			ST_SPIKE: begin
				elapsed = (dur > TIME_W'(ELAPSED_MAX)) ? ELAPSED_MAX : dur[15:0];
				if (!(enough && frame.settled)) begin
					if (over_max) begin
						tkind = TO_DURATION;
					end else if (over_window && !enough) begin
						tkind = TO_WINDOW;
					end
				end
			end
			ST_STAB: begin
				elapsed = (dur > TIME_W'(ELAPSED_MAX)) ? ELAPSED_MAX : dur[15:0];
				if (over_max) begin
					tkind = TO_DURATION;
				end else if (frame.settled && (settle_inc >= cfg.settle_frames)) begin
					finished = 1'b1;
				end
			end
			ST_END: begin
				elapsed = (dur > TIME_W'(ELAPSED_MAX)) ? ELAPSED_MAX : dur[15:0];
				finished = 1'b1;
			end
			default: begin
				finished = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			event_start_q <= '0;
			cooldown_start_q <= '0;
			spiked_mask_q <= '0;
			settle_count_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			event_start_q <= event_start_d;
			cooldown_start_q <= cooldown_start_d;
			spiked_mask_q <= spiked_mask_d;
			settle_count_q <= settle_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2.state <= state_d;
			res_s2.finished <= finished;
			res_s2.elapsed <= elapsed;
			res_s2.tkind <= tkind;
			res_s2.spiked_count <= popcount4(spiked_mask_d);
		end
	end

	assign result = res_s2;

endmodule

// File: hdl/multi_camera_motion_event_fsm.sv
// Top level of the multi-camera motion event block: configuration registers, camera
// lanes, merge stage and state machine. Depends on mcme_pkg, mcme_lane, mcme_merge, mcme_fsm.
`timescale 1ns / 1ps

// Usage
// Each input beat is one frame cycle: a millisecond timestamp, a mask of the cameras that
// measured and one Q0.16 changed-pixel ratio per camera. Each accepted beat yields exactly
// one result beat carrying the state after the frame, the finished flag, the elapsed event
// time, the timeout kind and the number of cameras that spiked in the current event.
// Both data channels use valid and stall; a beat moves when valid is high and stall low.
// An accepted input beat is registered in stage one and moves into the result register once
// that register is free, so a stalled result can hold the frame in stage one.
// Throughput is one beat per cycle while the receiver does not stall: the lanes and merge
// fill stage one, and the state machine updates its event registers as a frame leaves
// stage one, so that register loop sets the rate.
// When the receiver stalls, the result register holds its beat; stage one can still take
// one more frame, after which in_stall is raised until the result is taken.
// Configuration writes use cfg_valid/cfg_ready (always ready) and take effect at once;
// they are meant to be issued while no frame is in flight. Indexes beyond the register
// list are ignored.
// Reset (arst_n low) empties both stages, returns the machine to idle with cleared event
// registers and loads the register defaults. There is no clearing pass.

module multi_camera_motion_event_fsm
	import mcme_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input frame channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [MASK_W-1:0]     measured_mask,
	input  logic [RATIO_W-1:0]    ratio_cam0,
	input  logic [RATIO_W-1:0]    ratio_cam1,
	input  logic [RATIO_W-1:0]    ratio_cam2,
	input  logic [RATIO_W-1:0]    ratio_cam3,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            event_state,
	output logic                  event_done,
	output logic [15:0]           event_elapsed_ms,
	output logic [1:0]            timeout_kind,
	output logic [COUNT_W-1:0]    spiked_count
);

	cfg_t cfg_q;
	logic [RATIO_W-1:0] ratio_a [4];
	lane_t lanes [LANES];
	frame_t frame;
	frame_t frame_s1;
	logic [TIME_W-1:0] now_s1;
	logic valid_s1;
	logic valid_s2;
	logic out_free;
	logic step;
	logic take_in;
	result_t result;

	// Configuration registers. The port is always ready; each write takes the low bits
	// that the addressed register needs.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spike_level <= 16'd1311;
			cfg_q.quiet_level <= 16'd66;
			cfg_q.min_cameras <= 3'd1;
			cfg_q.window_ms <= 16'd150;
			cfg_q.max_event_ms <= 16'd2000;
			cfg_q.settle_frames <= 10'd3;
			cfg_q.cooldown_ms <= 16'd500;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPIKE_LEVEL:   cfg_q.spike_level <= cfg_data[RATIO_W-1:0];
				CFG_QUIET_LEVEL:   cfg_q.quiet_level <= cfg_data[RATIO_W-1:0];
				CFG_MIN_CAMERAS:   cfg_q.min_cameras <= cfg_data[COUNT_W-1:0];
				CFG_SPIKE_WINDOW:  cfg_q.window_ms <= cfg_data[15:0];
				CFG_MAX_EVENT:     cfg_q.max_event_ms <= cfg_data[15:0];
				CFG_SETTLE_FRAMES: cfg_q.settle_frames <= cfg_data[SETTLE_W-1:0];
				CFG_COOLDOWN:      cfg_q.cooldown_ms <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. The result register is free when empty or being taken; stage one
	// moves into it whenever it is free, and the input is refused only when stage one is
	// full and cannot move.
	assign out_free = !valid_s2 || !out_stall;
	assign step = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in = in_valid && !in_stall;

	// Camera lanes, one per carried ratio.
	assign ratio_a[0] = ratio_cam0;
	assign ratio_a[1] = ratio_cam1;
	assign ratio_a[2] = ratio_cam2;
	assign ratio_a[3] = ratio_cam3;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mcme_lane u_lane (
			.measured    (measured_mask[g]),
			.ratio       (ratio_a[g]),
			.spike_level (cfg_q.spike_level),
			.lane        (lanes[g])
		);
	end

	mcme_merge u_merge (
		.lanes       (lanes),
		.spike_level (cfg_q.spike_level),
		.quiet_level (cfg_q.quiet_level),
		.frame       (frame)
	);

	// Stage one: merged frame summary and its timestamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			frame_s1 <= frame;
			now_s1 <= now_ms;
		end
	end

	// Stage two: the state machine owns the result register.
	mcme_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.frame  (frame_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign event_state = result.state;
	assign event_done = result.finished;
	assign event_elapsed_ms = result.elapsed;
	assign timeout_kind = result.tkind;
	assign spiked_count = result.spiked_count;

endmodule

// File: hdl/mcme_checker.sv
// Port-level checks on the result channel of the motion event block, bound to the top level.
// Depends on mcme_pkg and multi_camera_motion_event_fsm.
`timescale 1ns / 1ps

module mcme_checker
	import mcme_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         event_state,
	input logic               event_done,
	input logic [1:0]         timeout_kind,
	input logic [COUNT_W-1:0] spiked_count
);

	// A completed event always lands in cooldown with no timeout.
	a_finish_cool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_done |-> event_state == ST_COOL && timeout_kind == TO_NONE)
		else $error("finished beat not in cooldown");

	// Any timeout drops the machine back to idle.
	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_kind != TO_NONE |-> event_state == ST_IDLE)
		else $error("timeout beat not in idle");

	// The end state is never entered or reported, and the spiked count never exceeds four.
	a_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_state != ST_END && spiked_count <= COUNT_W'(MASK_W))
		else $error("end state or bad spiked count reported");

	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

endmodule

bind multi_camera_motion_event_fsm mcme_checker u_mcme_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_state  (event_state),
	.event_done   (event_done),
	.timeout_kind (timeout_kind),
	.spiked_count (spiked_count)
);

// File: tb/tb_multi_camera_motion_event_fsm.sv
// Self-checking testbench for multi_camera_motion_event_fsm: frame beats in, one result beat out.
// Depends on mcme_pkg and the block itself; nothing else is read or loaded.
`timescale 1ns / 1ps

module tb_multi_camera_motion_event_fsm;
	import mcme_pkg::*;

	// Index past the end of the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
	localparam int IDLE_PERCENT = 35;
	localparam int HOLD_CYCLES = 50;
	localparam int TAIL_CYCLES = 4;

	// Shapes of frame the stimulus generator knows how to build.
	typedef enum int {
		FK_QUIET,
		FK_SPIKE,
		FK_BUSY,
		FK_MIDDLE,
		FK_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [MASK_W-1:0] mask;
		logic [3:0][RATIO_W-1:0] ratio;
	} cam_frame_t;

	// Every input of the block starts from a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TIME_W-1:0] now_ms = '0;
	logic [MASK_W-1:0] measured_mask = '0;
	logic [RATIO_W-1:0] ratio_cam0 = '0;
	logic [RATIO_W-1:0] ratio_cam1 = '0;
	logic [RATIO_W-1:0] ratio_cam2 = '0;
	logic [RATIO_W-1:0] ratio_cam3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] event_state;
	logic event_done;
	logic [15:0] event_elapsed_ms;
	logic [1:0] timeout_kind;
	logic [COUNT_W-1:0] spiked_count;

	multi_camera_motion_event_fsm dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.measured_mask(measured_mask),
		.ratio_cam0(ratio_cam0),
		.ratio_cam1(ratio_cam1),
		.ratio_cam2(ratio_cam2),
		.ratio_cam3(ratio_cam3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_state(event_state),
		.event_done(event_done),
		.event_elapsed_ms(event_elapsed_ms),
		.timeout_kind(timeout_kind),
		.spiked_count(spiked_count)
	);

	always #5 clk = ~clk;

	// Our own copy of the register file, updated whenever a write beat is accepted.
	logic [RATIO_W-1:0] lvl_spike;
	logic [RATIO_W-1:0] lvl_quiet;
	logic [COUNT_W-1:0] need_cams;
	logic [15:0] join_window_ms;
	logic [15:0] event_limit_ms;
	logic [SETTLE_W-1:0] settle_need;
	logic [15:0] cool_ms;

	// Our own copy of the event tracker's state.
	state_t ev_state;
	logic [TIME_W-1:0] ev_start;
	logic [TIME_W-1:0] cool_start;
	logic [MASK_W-1:0] cams_spiked;
	logic [SETTLE_W-1:0] quiet_run;

	cam_frame_t frames_to_send[$];
	result_t expected_results[$];
	cam_frame_t on_wire;
	result_t oldest;
	logic [TIME_W-1:0] clock_ms;
	logic steady = 1'b0;

	int failures = 0;
	int frames_accepted = 0;
	int results_checked = 0;
	int settings_used = 0;
	int events_finished = 0;
	int duration_timeouts = 0;
	int window_timeouts = 0;
	int hold_left = 0;
	int holds_done = 0;

	function automatic void restore_model();
		lvl_spike = 16'd1311;
		lvl_quiet = 16'd66;
		need_cams = 3'd1;
		join_window_ms = 16'd150;
		event_limit_ms = 16'd2000;
		settle_need = 10'd3;
		cool_ms = 16'd500;
		ev_state = ST_IDLE;
		ev_start = '0;
		cool_start = '0;
		cams_spiked = '0;
		quiet_run = '0;
	endfunction

	// Appends a frame at the tail of the pending queue.
	function automatic void queue_frame(input cam_frame_t f);
		frames_to_send.insert(frames_to_send.size(), f);
	endfunction

	// Appends a prediction at the tail of the expected queue.
	function automatic void expect_result(input result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// A fresh event starts with this frame's spiking cameras only.
	function automatic void open_event(input logic [TIME_W-1:0] stamp, input logic [MASK_W-1:0] hot);
		ev_state = ST_SPIKE;
		ev_start = stamp;
		cams_spiked = hot;
		quiet_run = '0;
	endfunction

	// Works out the result beat that one frame causes and advances the tracked state.
	function automatic result_t judge_frame(input cam_frame_t f);
		result_t r;
		logic [MASK_W-1:0] hot;
		logic [SUM_W-1:0] total;
		logic [RATIO_W-1:0] peak;
		int unsigned measured;
		int unsigned n_hot;
		logic calm;
		logic avg_hot;
		logic peak_hot;
		logic [TIME_W-1:0] dur;
		state_t entry;
		hot = '0;
		total = '0;
		peak = '0;
		measured = 0;
		entry = ev_state;
		r.finished = 1'b0;
		r.elapsed = '0;
		r.tkind = TO_NONE;
		// Cameras that did not measure are ignored entirely, whatever their ratio says.
		for (int i = 0; i < 4; i++) begin
			if (f.mask[i]) begin
				measured++;
				total += f.ratio[i];
				if (f.ratio[i] > peak)
					peak = f.ratio[i];
				if (f.ratio[i] > lvl_spike)
					hot[i] = 1'b1;
			end
		end
		// The average is compared without dividing: sum against level times count.
		calm = 64'(total) <= 64'(lvl_quiet) * 64'(measured);
		avg_hot = 64'(total) > 64'(lvl_spike) * 64'(measured);
		peak_hot = peak > lvl_spike;
		dur = f.now - ev_start;
		if (entry == ST_SPIKE || entry == ST_STAB || entry == ST_END)
			r.elapsed = (dur > 32'hFFFF) ? ELAPSED_MAX : dur[15:0];

		case (entry)
			ST_SPIKE: begin
				cams_spiked |= hot;
				n_hot = $countones(cams_spiked);
				if (n_hot >= need_cams && calm) begin
					ev_state = ST_STAB;
					quiet_run = 10'd1;
				end else if (dur > event_limit_ms || (dur > join_window_ms && n_hot < need_cams)) begin
					r.tkind = (dur > event_limit_ms) ? TO_DURATION : TO_WINDOW;
					ev_state = ST_IDLE;
				end
			end
			ST_STAB: begin
				if (dur > event_limit_ms) begin
					ev_state = ST_IDLE;
					r.tkind = TO_DURATION;
				end else if (calm) begin
					if (quiet_run != SETTLE_MAX)
						quiet_run++;
					// Enough quiet frames: the event finishes and goes straight to cooldown, skipping the end state.
					if (quiet_run >= settle_need) begin
						ev_state = ST_COOL;
						cool_start = f.now;
						r.finished = 1'b1;
					end
				end else if (avg_hot) begin
					open_event(f.now, hot);
				end else begin
					quiet_run = '0;
				end
			end
			ST_END: begin
				ev_state = ST_COOL;
				cool_start = f.now;
				r.finished = 1'b1;
			end
			ST_COOL: begin
				// An expired cooldown wins over a spike on the same frame.
				if (f.now - cool_start >= cool_ms)
					ev_state = ST_IDLE;
				else if (peak_hot)
					open_event(f.now, hot);
			end
			default: begin
				if (peak_hot)
					open_event(f.now, hot);
				else
					ev_state = ST_IDLE;
			end
		endcase

		r.state = ev_state;
		r.spiked_count = COUNT_W'($countones(cams_spiked));
		if (r.finished)
			events_finished++;
		if (r.tkind == TO_DURATION)
			duration_timeouts++;
		if (r.tkind == TO_WINDOW)
			window_timeouts++;
		return r;
	endfunction

	// Frame timestamps mostly creep forward; now and then they jump, and noise may land anywhere.
	function automatic logic [TIME_W-1:0] advance_clock(input logic wild);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (wild && pick < 20)
			clock_ms = $urandom;
		else if (pick < 85)
			clock_ms += $urandom_range(0, 40);
		else if (pick < 97)
			clock_ms += $urandom_range(41, 600);
		else
			clock_ms += $urandom_range(601, 5000);
		return clock_ms;
	endfunction

	function automatic logic [RATIO_W-1:0] above_spike();
		if (lvl_spike == ELAPSED_MAX)
			return ELAPSED_MAX;
		return RATIO_W'($urandom_range(32'(lvl_spike) + 1, 65535));
	endfunction

	function automatic cam_frame_t make_frame(input frame_kind_t kind, input logic [MASK_W-1:0] hot);
		cam_frame_t f;
		f.now = advance_clock(kind == FK_NOISE);
		f.mask = MASK_W'($urandom_range(0, 15));
		// Unmeasured cameras carry junk on purpose.
		for (int i = 0; i < 4; i++)
			f.ratio[i] = RATIO_W'($urandom);
		case (kind)
			FK_QUIET: begin
				if ($urandom_range(0, 9) == 0)
					f.mask = '0;
				for (int i = 0; i < 4; i++)
					if (f.mask[i])
						f.ratio[i] = RATIO_W'($urandom_range(0, lvl_quiet));
			end
			FK_SPIKE: begin
				f.mask = f.mask | hot;
				for (int i = 0; i < 4; i++) begin
					if (hot[i])
						f.ratio[i] = above_spike();
					else if (f.mask[i])
						f.ratio[i] = RATIO_W'($urandom_range(0, lvl_spike));
				end
			end
			FK_BUSY: begin
				if (f.mask == '0)
					f.mask = 4'hF;
				for (int i = 0; i < 4; i++)
					if (f.mask[i])
						f.ratio[i] = above_spike();
			end
			FK_MIDDLE: begin
				if (f.mask == '0)
					f.mask = 4'h1;
				for (int i = 0; i < 4; i++)
					if (f.mask[i] && lvl_quiet < lvl_spike)
						f.ratio[i] = RATIO_W'($urandom_range(32'(lvl_quiet) + 1, lvl_spike));
			end
			default: begin
			end
		endcase
		return f;
	endfunction

	function automatic void push_frame(input logic [TIME_W-1:0] stamp, input logic [MASK_W-1:0] mask,
			input logic [RATIO_W-1:0] r0, input logic [RATIO_W-1:0] r1,
			input logic [RATIO_W-1:0] r2, input logic [RATIO_W-1:0] r3);
		cam_frame_t f;
		f.now = stamp;
		f.mask = mask;
		f.ratio = {r3, r2, r1, r0};
		queue_frame(f);
	endfunction

	// One plausible event: a little idle, a spike that others join, settling, then cooldown.
	// Re-opening spikes and half-quiet frames are mixed in so the re-open and settle-reset paths get visited.
	function automatic int unsigned queue_event();
		int unsigned n;
		int unsigned settle_len;
		n = 0;
		repeat ($urandom_range(0, 2)) begin
			queue_frame(make_frame(FK_QUIET, '0));
			n++;
		end
		repeat ($urandom_range(1, 3)) begin
			queue_frame(make_frame(FK_SPIKE, MASK_W'($urandom_range(1, 15))));
			n++;
		end
		if ($urandom_range(0, 3) == 0) begin
			queue_frame(make_frame(FK_MIDDLE, '0));
			n++;
		end
		settle_len = (settle_need > 8) ? 8 : settle_need;
		repeat (settle_len + $urandom_range(0, 2)) begin
			case ($urandom_range(0, 11))
				0, 1: queue_frame(make_frame(FK_BUSY, '0));
				2: queue_frame(make_frame(FK_MIDDLE, '0));
				default: queue_frame(make_frame(FK_QUIET, '0));
			endcase
			n++;
		end
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 3) == 0)
				queue_frame(make_frame(FK_SPIKE, MASK_W'($urandom_range(1, 15))));
			else
				queue_frame(make_frame(FK_QUIET, '0));
			n++;
		end
		return n;
	endfunction

	// Waits until every queued frame has gone in and every result beat has come back.
	// Sampled on the falling edge so that the driver's updates of the same edge are settled.
	task automatic drain();
		do
			@(negedge clk);
		while (frames_to_send.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_SPIKE_LEVEL: lvl_spike = value;
			CFG_QUIET_LEVEL: lvl_quiet = value;
			CFG_MIN_CAMERAS: need_cams = value[COUNT_W-1:0];
			CFG_SPIKE_WINDOW: join_window_ms = value;
			CFG_MAX_EVENT: event_limit_ms = value;
			CFG_SETTLE_FRAMES: settle_need = value[SETTLE_W-1:0];
			CFG_COOLDOWN: cool_ms = value;
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] spike, input logic [15:0] quiet,
			input logic [15:0] cams, input logic [15:0] window, input logic [15:0] limit,
			input logic [15:0] settle, input logic [15:0] cool);
		write_reg(CFG_SPIKE_LEVEL, spike);
		write_reg(CFG_QUIET_LEVEL, quiet);
		write_reg(CFG_MIN_CAMERAS, cams);
		write_reg(CFG_SPIKE_WINDOW, window);
		write_reg(CFG_MAX_EVENT, limit);
		write_reg(CFG_SETTLE_FRAMES, settle);
		write_reg(CFG_COOLDOWN, cool);
		settings_used++;
	endtask

	task automatic run_phase(input int unsigned n_frames);
		int unsigned queued;
		queued = 0;
		while (queued < n_frames) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_frame(make_frame(FK_NOISE, '0));
				queued++;
			end else begin
				queued += queue_event();
			end
		end
		drain();
	endtask

	// Sender: takes frames from the queue, idles at random and holds a stalled beat steady.
	// Whether a new beat is offered never looks at in_stall; in_stall only holds a beat on offer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expect_result(judge_frame(on_wire));
				frames_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (frames_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					on_wire = frames_to_send.pop_front();
					in_valid <= 1'b1;
					now_ms <= on_wire.now;
					measured_mask <= on_wire.mask;
					ratio_cam0 <= on_wire.ratio[0];
					ratio_cam1 <= on_wire.ratio[1];
					ratio_cam2 <= on_wire.ratio[2];
					ratio_cam3 <= on_wire.ratio[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input longint unsigned want, input longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Receiver: checks each result beat against the oldest prediction and stalls at random.
	// Twice in the run it holds off for a long stretch while frames are still on offer, so
	// that both pipeline stages fill and the block has to push back on its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, state %0d", $time, event_state);
					failures++;
				end else begin
					oldest = expected_results.pop_front();
					report_field("event_state", oldest.state, event_state);
					report_field("event_done", oldest.finished, event_done);
					report_field("event_elapsed_ms", oldest.elapsed, event_elapsed_ms);
					report_field("timeout_kind", oldest.tkind, timeout_kind);
					report_field("spiked_count", oldest.spiked_count, spiked_count);
				end
				results_checked++;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (holds_done < 2 && results_checked >= 100 + 200 * holds_done && in_valid) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && $urandom_range(0, 99) < IDLE_PERCENT;
			end
		end
	end

	// A generous ceiling on the whole run; a correct run ends far sooner.
	initial begin
		#5_000_000;
		$display("multi_camera_motion_event_fsm verification failed");
		$finish;
	end

	initial begin
		restore_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset settings.
		push_frame(32'd0, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // nobody measured
		push_frame(32'd3, 4'hF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(32'd7, 4'h1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // spike on camera 0 only
		push_frame(32'd20, 4'h3, 16'd66, 16'd0, 16'hFFFF, 16'hFFFF);      // average half the quiet level
		push_frame(32'd30, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // re-opens while settling
		push_frame(32'd40, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'd50, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'd60, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);             // settles into cooldown
		push_frame(32'd100, 4'h4, 16'd0, 16'd0, 16'd2000, 16'd0);         // re-opens in cooldown
		push_frame(32'd100100, 4'h1, 16'd1000, 16'd0, 16'd0, 16'd0);      // saturated elapsed, too long
		push_frame(32'd100200, 4'h2, 16'd0, 16'd1312, 16'd0, 16'd0);      // one above the level
		push_frame(32'd100210, 4'h2, 16'd0, 16'd1311, 16'd0, 16'd0);      // exactly at the level
		push_frame(32'd100220, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_frame(32'd100230, 4'hF, 16'd67, 16'd67, 16'd67, 16'd67);    // just too busy to settle
		push_frame(32'd100240, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'd100250, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'd100260, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'd100760, 4'hF, 16'hFFFF, 16'd0, 16'd0, 16'd0);      // cooldown expired first
		drain();

		// Three cameras needed now; the clock wraps in the middle of an event.
		write_reg(CFG_MIN_CAMERAS, 16'd3);
		push_frame(32'hFFFF_FF00, 4'hF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		push_frame(32'h0000_00C8, 4'h1, 16'd500, 16'd0, 16'd0, 16'd0);    // window runs out
		push_frame(32'h0000_00D0, 4'h7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		push_frame(32'h0000_00D5, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
		push_frame(32'h0000_08A6, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);      // too long while settling
		drain();

		clock_ms = $urandom;
		apply_settings(16'd1311, 16'd66, 16'd1, 16'd150, 16'd2000, 16'd3, 16'd500);
		run_phase(60);
		// The extremes: everything spikes and nothing waits, then the opposite, then a mixture.
		apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
		run_phase(25);
		apply_settings(16'hFFFF, 16'hFFFF, 16'd7, 16'hFFFF, 16'hFFFF, 16'd1023, 16'hFFFF);
		run_phase(25);
		apply_settings(16'd0, 16'hFFFF, 16'd4, 16'hFFFF, 16'hFFFF, 16'd1023, 16'hFFFF);
		run_phase(25);
		write_reg(CFG_UNUSED_INDEX, 16'hFFFF);

		for (int p = 0; p < 5; p++) begin
			logic [15:0] spike;
			spike = 16'($urandom_range(300, 20000));
			apply_settings(spike, 16'($urandom_range(0, spike / 2)),
				($urandom_range(0, 5) == 0) ? 16'($urandom_range(5, 7)) : 16'($urandom_range(0, 4)),
				16'($urandom_range(20, 400)), 16'($urandom_range(150, 3000)),
				16'($urandom_range(1, 6)), 16'($urandom_range(0, 800)));
			// One phase runs flat out on both sides.
			steady = (p == 2);
			run_phase(60);
		end
		steady = 1'b0;
		drain();

		$display("Ran %0d frame beats under %0d register settings.", frames_accepted, settings_used);
		$display("Seen: %0d finished events, %0d duration and %0d window timeouts.",
			events_finished, duration_timeouts, window_timeouts);
		if (failures == 0) begin
			$display("multi_camera_motion_event_fsm verification clean");
		end else begin
			$display("multi_camera_motion_event_fsm verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/mcme_pkg.sv
hdl/mcme_lane.sv
hdl/mcme_merge.sv
hdl/mcme_fsm.sv
hdl/multi_camera_motion_event_fsm.sv
hdl/mcme_checker.sv
tb/tb_multi_camera_motion_event_fsm.sv
